@@ design/grain_time_stamp_queue_unit_defines.svh @@
// Assertion macros shared by the grain time stamp queue RTL.
`ifndef GRAIN_TIME_STAMP_QUEUE_UNIT_DEFINES_SVH
`define GRAIN_TIME_STAMP_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define GTSQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define GTSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gtsq_pkg.sv @@
// Package: sizes, codes, types and constants of the grain time stamp queue.
`default_nettype none

package gtsq_pkg;

    // Ring and grain geometry
    localparam int RING_DEPTH   = 64;
    localparam int GRAIN_FRAMES = 2048;

    localparam int IDX_W    = $clog2(RING_DEPTH);
    localparam int GRAIN_W  = $clog2(GRAIN_FRAMES);
    localparam int SPACE_W  = $clog2(GRAIN_FRAMES + 1);
    localparam int FRAME_W  = 16;
    localparam int CNT_W    = (SPACE_W > FRAME_W) ? SPACE_W : FRAME_W;
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int PROD_W   = SPACE_W + PERIOD_W;
    localparam int DROP_W   = 6;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SPACE_W-1:0] GRAIN_SPACE = SPACE_W'(GRAIN_FRAMES);
    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(RING_DEPTH - 1);
    localparam logic [DROP_W-1:0]  DROP_MAX    = '1;

    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = PERIOD_W'(89478);

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_PRIME   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRODUCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSED     = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_PAD,
        ST_WALK,
        ST_READ,
        ST_OUT
    } state_t;

    // Request to the time step unit
    typedef struct packed {
        logic               load;
        logic [SPACE_W-1:0] frames;
    } step_req_t;

endpackage

`default_nettype wire

@@ design/grain_time_stamp_queue_unit.sv @@
// Top level: grain time stamp ring with a small sequencer around a shared time step unit.
// Prime and unused kinds go straight from accept to the output state. Consume walks the
// head grain by grain, then reads the ring. Produce runs a multiply and an add/clamp step
// for each time step, then closes padding grains, then goes to the output state.
// One word at a time; in_ready is low from accept until the result is registered.
// Reset (async, active low) clears all control state, config registers and stamp valid bits.
`default_nettype none

module grain_time_stamp_queue_unit
    import gtsq_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [KIND_W-1:0]           kind,
    input  wire logic signed [TIME_W-1:0]    start_time,
    input  wire logic [FRAME_W-1:0]          produce_frames,
    input  wire logic [FRAME_W-1:0]          total_frames,
    input  wire logic [FRAME_W-1:0]          consume_frames,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [TIME_W-1:0]         time_out,
    output logic [DROP_W-1:0]                dropped_count,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [TIME_W-1:0]           cfg_data
);

    `include "grain_time_stamp_queue_unit_defines.svh"

    state_t state_reg, state_next;

    // Config registers
    logic signed [TIME_W-1:0] end_time_reg;
    logic [PERIOD_W-1:0]      frame_period_reg;
    logic                     reversed_reg;

    // Queue state
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [IDX_W-1:0]         tail_reg, tail_next;
    logic [GRAIN_W-1:0]       fog_reg, fog_next;
    logic [GRAIN_W-1:0]       offset_reg, offset_next;
    logic signed [TIME_W-1:0] last_time_reg, last_time_next;
    logic [DROP_W-1:0]        drops_reg, drops_next;
    logic [RING_DEPTH-1:0]    valid_reg, valid_next;

    // Work registers
    logic signed [TIME_W-1:0] work_time_reg, work_time_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         pad_reg, pad_next;
    logic [SPACE_W-1:0]       space_reg, space_next;
    logic [IDX_W-1:0]         walk_reg, walk_next;
    logic                     push_pend_reg, push_pend_next;
    logic                     use_ram_reg, use_ram_next;
    logic [IDX_W-1:0]         rd_addr_reg, rd_addr_next;
    logic                     rd_valid_reg;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [TIME_W-1:0] time_out_reg, time_out_next;
    logic [DROP_W-1:0]        dropped_reg, dropped_next;

    // Memory and step unit hookup
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [TIME_W-1:0]        ram_wdata;
    logic [TIME_W-1:0]        ram_rdata;
    step_req_t                step_req;
    logic signed [TIME_W-1:0] step_time;

    // Shared helpers
    logic                     accept;
    logic                     cnt_ge_space;
    logic                     pad_ge_space;
    logic [CNT_W-1:0]         space_ext;
    logic                     push_en;
    logic signed [TIME_W-1:0] push_time;
    logic [IDX_W-1:0]         tail_inc;
    logic                     ring_full;
    logic [IDX_W-1:0]         walk_inc;
    logic [CNT_W-1:0]         pad_init;
    logic                     out_free;

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign space_ext    = CNT_W'(space_reg);
    assign cnt_ge_space = (cnt_reg >= space_ext);
    assign pad_ge_space = (pad_reg != '0) && (pad_reg >= space_ext);
    assign tail_inc     = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign walk_inc     = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
    assign ring_full    = (tail_inc == head_reg);
    assign pad_init     = (total_frames > produce_frames) ?
                          CNT_W'(total_frames - produce_frames) : '0;
    assign out_free     = !out_valid_reg || out_ready;

    // Grain closes: after a full-grain time step, or on a padding grain
    assign push_en   = ((state_reg == ST_ADD) && push_pend_reg) ||
                       ((state_reg == ST_PAD) && pad_ge_space);
    assign push_time = (state_reg == ST_ADD) ? step_time : work_time_reg;

    // Time step unit request
    assign step_req.load   = (state_reg == ST_MUL) && (cnt_reg != '0);
    assign step_req.frames = cnt_ge_space ? space_reg : cnt_reg[SPACE_W-1:0];

    gtsq_time_step u_step (
        .clk          (clk),
        .req          (step_req),
        .frame_period (frame_period_reg),
        .reversed     (reversed_reg),
        .time_in      (work_time_reg),
        .end_time     (end_time_reg),
        .time_out     (step_time)
    );

    // Stamp ring
    assign ram_we    = (push_en && !ring_full) ||
                       (accept && (kind == KIND_PRIME));
    assign ram_waddr = (state_reg == ST_IDLE) ? '0 : tail_inc;
    assign ram_wdata = (state_reg == ST_IDLE) ? start_time : push_time;

    gtsq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_PRODUCE: state_next = ST_MUL;
                        KIND_CONSUME: state_next = ST_WALK;
                        default:      state_next = ST_OUT;
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = (cnt_reg != '0) ? ST_ADD : ST_PAD;
            end
            ST_ADD:
            begin
                state_next = ST_MUL;
            end
            ST_PAD:
            begin
                if (!pad_ge_space)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_WALK:
            begin
                if (!cnt_ge_space || (walk_reg == tail_reg))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fog_next       = fog_reg;
        offset_next    = offset_reg;
        last_time_next = last_time_reg;
        drops_next     = drops_reg;
        valid_next     = valid_reg;
        work_time_next = work_time_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        space_next     = space_reg;
        walk_next      = walk_reg;
        push_pend_next = push_pend_reg;
        use_ram_next   = use_ram_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg;
        time_out_next  = time_out_reg;
        dropped_next   = dropped_reg;

        // Consumer takes the result word
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Stamp push, shared by time steps and padding grains
        if (push_en)
        begin
            if (ring_full)
            begin
                if (drops_reg != DROP_MAX)
                begin
                    drops_next = drops_reg + 1'b1;
                end
            end
            else
            begin
                tail_next            = tail_inc;
                valid_next[tail_inc] = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    use_ram_next   = 1'b0;
                    work_time_next = last_time_reg;
                    case (kind)
                        KIND_PRIME:
                        begin
                            last_time_next = start_time;
                            work_time_next = start_time;
                            head_next      = '0;
                            tail_next      = '0;
                            fog_next       = '0;
                            offset_next    = '0;
                            valid_next[0]  = 1'b1;
                        end
                        KIND_PRODUCE:
                        begin
                            cnt_next   = CNT_W'(produce_frames);
                            pad_next   = pad_init;
                            space_next = GRAIN_SPACE - SPACE_W'(fog_reg);
                        end
                        KIND_CONSUME:
                        begin
                            use_ram_next = 1'b1;
                            cnt_next     = CNT_W'(consume_frames);
                            space_next   = GRAIN_SPACE - SPACE_W'(offset_reg);
                            walk_next    = head_reg;
                        end
                        default:
                        begin
                            work_time_next = last_time_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                push_pend_next = cnt_ge_space;
            end
            ST_ADD:
            begin
                work_time_next = step_time;
                if (push_pend_reg)
                begin
                    cnt_next   = cnt_reg - space_ext;
                    space_next = GRAIN_SPACE;
                end
                else
                begin
                    space_next = space_reg - cnt_reg[SPACE_W-1:0];
                    cnt_next   = '0;
                end
            end
            ST_PAD:
            begin
                if (pad_ge_space)
                begin
                    pad_next   = pad_reg - space_ext;
                    space_next = GRAIN_SPACE;
                end
                else
                begin
                    fog_next       = GRAIN_W'(CNT_W'(GRAIN_SPACE - space_reg) + pad_reg);
                    last_time_next = work_time_reg;
                end
            end
            ST_WALK:
            begin
                if (cnt_ge_space)
                begin
                    if (walk_reg == tail_reg)
                    begin
                        // starved: return the tail stamp, head and offset stay
                        rd_addr_next = walk_reg;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - space_ext;
                        walk_next  = walk_inc;
                        space_next = GRAIN_SPACE;
                    end
                end
                else
                begin
                    head_next    = walk_reg;
                    offset_next  = GRAIN_W'(CNT_W'(GRAIN_SPACE - space_reg) + cnt_reg);
                    rd_addr_next = walk_reg;
                end
            end
            ST_READ:
            begin
                use_ram_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dropped_next   = drops_reg;
                    if (use_ram_reg)
                    begin
                        time_out_next = rd_valid_reg ? $signed(ram_rdata) : '0;
                    end
                    else
                    begin
                        time_out_next = work_time_reg;
                    end
                end
            end
            default:
            begin
                use_ram_next = use_ram_reg;
            end
        endcase
    end

    // Control state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            end_time_reg     <= '0;
            frame_period_reg <= FRAME_PERIOD_RESET;
            reversed_reg     <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fog_reg          <= '0;
            offset_reg       <= '0;
            last_time_reg    <= '0;
            drops_reg        <= '0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fog_reg       <= fog_next;
            offset_reg    <= offset_next;
            last_time_reg <= last_time_next;
            drops_reg     <= drops_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_END_TIME:     end_time_reg     <= $signed(cfg_data);
                    CFG_FRAME_PERIOD: frame_period_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_REVERSED:     reversed_reg     <= cfg_data[0];
                    default:          reversed_reg     <= reversed_reg;
                endcase
            end
        end
    end

    // Work and payload registers
    always_ff @(posedge clk)
    begin
        work_time_reg <= work_time_next;
        cnt_reg       <= cnt_next;
        pad_reg       <= pad_next;
        space_reg     <= space_next;
        walk_reg      <= walk_next;
        push_pend_reg <= push_pend_next;
        use_ram_reg   <= use_ram_next;
        rd_addr_reg   <= rd_addr_next;
        rd_valid_reg  <= valid_reg[rd_addr_reg];
        time_out_reg  <= time_out_next;
        dropped_reg   <= dropped_next;
    end

    assign out_valid     = out_valid_reg;
    assign time_out      = time_out_reg;
    assign dropped_count = dropped_reg;

    // Checks
    `GTSQ_ASSERT_NEXT(a_full_push_keeps_tail, push_en && ring_full, tail_reg == $past(tail_reg),
        "tail moved on a dropped stamp")
    `GTSQ_ASSERT_NEXT(a_drops_saturate, drops_reg == DROP_MAX, drops_reg == DROP_MAX,
        "drop counter left saturation")
    `GTSQ_ASSERT_NEXT(a_mul_then_add, state_reg == ST_MUL && cnt_reg != '0, state_reg == ST_ADD,
        "time step multiply not followed by add")
    `GTSQ_ASSERT_SAME(a_partial_step_fits, state_reg == ST_ADD && !push_pend_reg,
        cnt_reg < space_ext, "partial step would overrun the open grain")

endmodule

`default_nettype wire

@@ design/gtsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gtsq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/gtsq_time_step.sv @@
// Shared time step unit: frames times period, signed add or subtract with saturation, end clamp.
`default_nettype none

module gtsq_time_step
    import gtsq_pkg::*;
(
    input  wire logic                     clk,
    input  wire step_req_t                req,
    input  wire logic [PERIOD_W-1:0]      frame_period,
    input  wire logic                     reversed,
    input  wire logic signed [TIME_W-1:0] time_in,
    input  wire logic signed [TIME_W-1:0] end_time,
    output logic signed [TIME_W-1:0]      time_out
);

    logic [PROD_W-1:0]        product_reg;
    logic [PROD_W-1:0]        product_next;
    logic signed [TIME_W:0]   t_ext;
    logic signed [TIME_W:0]   d_ext;
    logic signed [TIME_W:0]   sum;
    logic signed [TIME_W-1:0] sat;

    // Stage one: delta = frames * period
    assign product_next = PROD_W'(req.frames) * PROD_W'(frame_period);

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            product_reg <= product_next;
        end
    end

    // Stage two: step in the playback direction, saturate, clamp at end
    assign t_ext = {time_in[TIME_W-1], time_in};
    assign d_ext = $signed({{(TIME_W + 1 - PROD_W){1'b0}}, product_reg});
    assign sum   = reversed ? (t_ext - d_ext) : (t_ext + d_ext);

    always_comb
    begin
        if (sum[TIME_W] != sum[TIME_W-1])
        begin
            sat = reversed ? TIME_MIN : TIME_MAX;
        end
        else
        begin
            sat = sum[TIME_W-1:0];
        end
        time_out = (sat >= end_time) ? end_time : sat;
    end

endmodule

`default_nettype wire

@@ test/gtsq_stamp_checker.sv @@
// Checker for the grain time stamp queue: mirrors the stamp ring and compares every result word.
module gtsq_stamp_checker
    import gtsq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [TIME_W-1:0] start_time,
    input  logic [FRAME_W-1:0]       produce_frames,
    input  logic [FRAME_W-1:0]       total_frames,
    input  logic [FRAME_W-1:0]       consume_frames,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [TIME_W-1:0] time_out,
    input  logic [DROP_W-1:0]        dropped_count,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [TIME_W-1:0]        cfg_data,
    output int                       stamps_owed,
    output int                       bad_words,
    output int                       words_checked
);

    // One expected result word, tagged with the kind that caused it
    typedef struct {
        logic [KIND_W-1:0] kind;
        longint            stamp;
        logic [DROP_W-1:0] drops;
    } owed_word_t;

    owed_word_t owed_q[$];

    // Mirror of the ring and its pointers
    longint              ring_m [RING_DEPTH];
    logic [IDX_W-1:0]    head_m;
    logic [IDX_W-1:0]    tail_m;
    int unsigned         open_frames;
    int unsigned         play_offset;
    longint              last_stamp;
    logic [DROP_W-1:0]   drop_tally;

    // Mirror of the registers
    longint              end_m;
    logic [PERIOD_W-1:0] period_m;
    logic                rev_m;

    function automatic void clear_model();
        for (int i = 0; i < RING_DEPTH; i++)
            ring_m[i] = 0;
        head_m      = '0;
        tail_m      = '0;
        open_frames = 0;
        play_offset = 0;
        last_stamp  = 0;
        drop_tally  = '0;
        end_m       = 0;
        period_m    = FRAME_PERIOD_RESET;
        rev_m       = 1'b0;
    endfunction

    // Advance time by a frame count, saturating, then clamp at the end time
    function automatic longint step_time(longint t, int unsigned frames);
        longint span;
        longint r;
        span = longint'(frames) * longint'(period_m);
        if (rev_m)
            r = (t < TIME_MIN + span) ? TIME_MIN : t - span;
        else
            r = (t > TIME_MAX - span) ? TIME_MAX : t + span;
        if (r >= end_m)
            r = end_m;
        return r;
    endfunction

    // Close the open grain; the stamp is lost when the ring is full
    function automatic void push_stamp(longint t);
        logic [IDX_W-1:0] nxt;
        nxt = tail_m + 1'b1;
        if (nxt == head_m)
        begin
            if (drop_tally != DROP_MAX)
                drop_tally = drop_tally + 1'b1;
        end
        else
        begin
            ring_m[nxt] = t;
            tail_m      = nxt;
        end
        open_frames = 0;
    endfunction

    function automatic void produce_slice(int unsigned prod, int unsigned total);
        longint      t;
        int unsigned space;
        int unsigned pad;
        t     = last_stamp;
        space = GRAIN_FRAMES - open_frames;
        pad   = (total > prod) ? total - prod : 0;
        while (prod >= space)
        begin
            t = step_time(t, space);
            push_stamp(t);
            prod  -= space;
            space  = GRAIN_FRAMES;
        end
        if (prod > 0)
        begin
            t = step_time(t, prod);
            open_frames += prod;
            space       -= prod;
        end
        // padding closes grains without moving time
        while (pad > 0 && pad >= space)
        begin
            push_stamp(t);
            pad   -= space;
            space  = GRAIN_FRAMES;
        end
        open_frames += pad;
        last_stamp   = t;
    endfunction

    // Walk the head by grains; a starved walk leaves head and offset alone
    function automatic longint consume_walk(int unsigned n);
        logic [IDX_W-1:0] h;
        int unsigned      off;
        int unsigned      avail;
        h     = head_m;
        off   = play_offset;
        avail = GRAIN_FRAMES - off;
        while (n >= avail)
        begin
            off  = 0;
            n   -= avail;
            if (h == tail_m)
                return ring_m[h];
            h     = h + 1'b1;
            avail = GRAIN_FRAMES;
        end
        head_m      = h;
        play_offset = off + n;
        return ring_m[h];
    endfunction

    // Expected result word for the input word on the ports
    function automatic owed_word_t predict_word();
        owed_word_t w;
        w.kind  = kind;
        w.stamp = last_stamp;
        case (kind)
            KIND_PRIME:
            begin
                last_stamp  = start_time;
                head_m      = '0;
                tail_m      = '0;
                open_frames = 0;
                play_offset = 0;
                ring_m[0]   = start_time;
                w.stamp     = last_stamp;
            end
            KIND_PRODUCE:
            begin
                produce_slice(produce_frames, total_frames);
                w.stamp = last_stamp;
            end
            KIND_CONSUME:
                w.stamp = consume_walk(consume_frames);
            default: ;
        endcase
        w.drops = drop_tally;
        return w;
    endfunction

    // Register writes, result compare, then prediction for the accepted word
    always @(posedge clk or negedge rst_n)
    begin : watch
        owed_word_t w;
        if (!rst_n)
        begin
            clear_model();
            owed_q.delete();
            bad_words     = 0;
            words_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_END_TIME)
                    end_m = $signed(cfg_data);
                else if (cfg_index == CFG_FRAME_PERIOD)
                    period_m = cfg_data[PERIOD_W-1:0];
                else if (cfg_index == CFG_REVERSED)
                    rev_m = cfg_data[0];
            end
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected result word: time_out %h dropped_count %0d",
                                 time_out, dropped_count);
                end
                else
                begin
                    w = owed_q.pop_front();
                    words_checked++;
                    if (time_out !== w.stamp || dropped_count !== w.drops)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display("kind %0d: time_out exp %h got %h, drops exp %0d got %0d",
                                     w.kind, w.stamp, time_out, w.drops, dropped_count);
                    end
                end
            end
            if (in_valid && in_ready)
                owed_q.push_back(predict_word());
        end
        stamps_owed = owed_q.size();
    end

endmodule

@@ test/tb.sv @@
// Testbench top: reset, register settings and input words for the grain time stamp queue.
module tb;
    import gtsq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 175;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind           = KIND_PRIME;
    logic signed [TIME_W-1:0] start_time     = '0;
    logic [FRAME_W-1:0]       produce_frames = '0;
    logic [FRAME_W-1:0]       total_frames   = '0;
    logic [FRAME_W-1:0]       consume_frames = '0;
    logic                     out_valid;
    logic                     out_ready      = 1'b0;
    logic signed [TIME_W-1:0] time_out;
    logic [DROP_W-1:0]        dropped_count;
    logic                     cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index      = CFG_END_TIME;
    logic [TIME_W-1:0]        cfg_data       = '0;

    int     stamps_owed;
    int     bad_words;
    int     words_checked;
    int     cycle_count   = 0;
    int     settings_used = 1;
    int     kind_seen [4] = '{0, 0, 0, 0};
    longint end_now       = 0;
    logic   steady        = 1'b0;

    grain_time_stamp_queue_unit DUT (.*);

    gtsq_stamp_checker u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("grain_time_stamp_queue_unit test failed");
            $finish;
        end
    end

    // Result side stalls, none during the steady phase
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 34);

    // Present one word after a random gap; returns at the falling edge after accept
    task automatic send_word(logic [KIND_W-1:0] k, longint st, logic [FRAME_W-1:0] pf,
                             logic [FRAME_W-1:0] tf, logic [FRAME_W-1:0] cf);
        while (!steady && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        start_time     <= st;
        produce_frames <= pf;
        total_frames   <= tf;
        consume_frames <= cf;
        kind_seen[k] = kind_seen[k] + 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Drain every owed result, then load all three registers
    task automatic apply_setting(longint e, logic [PERIOD_W-1:0] p, logic r);
        in_valid <= 1'b0;
        while (stamps_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(CFG_END_TIME, e);
        write_reg(CFG_FRAME_PERIOD, {{(TIME_W-PERIOD_W){1'b0}}, p});
        write_reg(CFG_REVERSED, {{(TIME_W-1){1'b0}}, r});
        end_now = e;
        settings_used++;
    endtask

    // Mostly short slices, many near grain edges, some full width
    function automatic logic [FRAME_W-1:0] pick_frames();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return FRAME_W'($urandom_range(0, 2100));
        if (roll < 70)
            return FRAME_W'(GRAIN_FRAMES * $urandom_range(1, 4) + $urandom_range(0, 4) - 2);
        if (roll < 90)
            return FRAME_W'($urandom_range(0, 12000));
        return FRAME_W'($urandom_range(0, 65535));
    endfunction

    // Start times: random, just below the clamp point, near zero, or near the extremes
    function automatic longint pick_start();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return end_now - (longint'($urandom) << $urandom_range(0, 12));
            2: return longint'(int'($urandom));
            3: return TIME_MAX - longint'($urandom_range(0, 70000));
            default: return TIME_MIN + longint'($urandom);
        endcase
    endfunction

    task automatic send_random();
        int unsigned       roll;
        logic [KIND_W-1:0] k;
        logic [FRAME_W-1:0] pf;
        logic [FRAME_W-1:0] tf;
        longint            st;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            k = KIND_PRIME;
        else if (roll < 7)
            k = KIND_SPARE;
        else if (roll < 54)
            k = KIND_PRODUCE;
        else
            k = KIND_CONSUME;
        st = (k == KIND_PRIME) ? pick_start() : longint'({$urandom, $urandom});
        pf = pick_frames();
        tf = $urandom_range(0, 1) ? FRAME_W'(pf + $urandom_range(0, 2500)) : pick_frames();
        send_word(k, st, pf, tf, pick_frames());
    endtask

    initial
    begin : stimulus
        longint e;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset register values
        send_word(KIND_CONSUME, 0, '0, '0, '0);
        send_word(KIND_CONSUME, 0, '0, '0, '1);           // starved walk
        send_word(KIND_SPARE, {$urandom, $urandom}, '1, '1, '1);
        send_word(KIND_PRIME, TIME_MIN, '0, '0, '0);
        send_word(KIND_PRODUCE, 0, '1, '1, '0);           // 31 grains
        send_word(KIND_PRODUCE, 0, '0, '1, '0);           // padding only, ring fills
        send_word(KIND_PRODUCE, 0, 16'd100, 16'd50, '0);  // total below produced: no padding
        send_word(KIND_PRODUCE, 0, '0, '1, '0);           // drops pile up
        send_word(KIND_PRODUCE, 0, '0, '1, '0);           // drop count saturates
        send_word(KIND_CONSUME, 0, '0, '0, '0);
        send_word(KIND_CONSUME, 0, '0, '0, 16'd2047);
        send_word(KIND_CONSUME, 0, '0, '0, 16'd1);
        send_word(KIND_CONSUME, 0, '0, '0, '1);
        send_word(KIND_CONSUME, 0, '0, '0, '1);
        send_word(KIND_CONSUME, 0, '0, '0, '1);
        send_word(KIND_PRIME, TIME_MAX, '0, '0, '0);
        send_word(KIND_PRODUCE, 0, 16'd1, 16'd1, '0);     // saturates, then clamps
        send_word(KIND_PRODUCE, 0, 16'd2047, '0, '0);     // exactly closes the open grain
        send_word(KIND_PRIME, -64'sd1, '0, '0, '0);
        send_word(KIND_PRODUCE, 0, 16'd1, 16'd2048, '0);  // padding lands on the grain edge
        send_word(KIND_CONSUME, 0, '0, '0, 16'd2048);

        // Random phases, each under its own register setting and opened by a prime
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: apply_setting(TIME_MAX, '1, 1'b0);
                1: apply_setting(TIME_MIN, '0, 1'b1);
                2: apply_setting(TIME_MAX, $urandom, 1'b1);
                3: apply_setting(0, FRAME_PERIOD_RESET, 1'b1);
                default:
                begin
                    e = $urandom_range(0, 1) ? longint'({$urandom, $urandom})
                                             : longint'(int'($urandom)) <<< 12;
                    apply_setting(e, $urandom >> $urandom_range(0, 20),
                                  1'($urandom_range(0, 1)));
                end
            endcase
            steady = (ph == 3);
            send_word(KIND_PRIME, pick_start(), pick_frames(), pick_frames(), pick_frames());
            repeat (PHASE_WORDS - 1) send_random();
        end

        in_valid <= 1'b0;
        steady = 1'b0;
        while (stamps_owed != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("Sent %0d prime, %0d produce, %0d consume and %0d spare-kind words under %0d settings.",
                 kind_seen[KIND_PRIME], kind_seen[KIND_PRODUCE], kind_seen[KIND_CONSUME],
                 kind_seen[KIND_SPARE], settings_used);
        $display("Compared %0d result words with the ring model, %0d mismatched.",
                 words_checked, bad_words);
        if (bad_words == 0 && stamps_owed == 0)
            $display("grain_time_stamp_queue_unit test passed");
        else
            $display("grain_time_stamp_queue_unit test failed");
        $finish;
    end

endmodule
